// ----- design/wpcb_pkg.sv -----
`default_nettype none

package wpcb_pkg;

    // channel width and full-scale value
    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // operation codes on the op field
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_APPLY   = 2'd2;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // classified word kinds carried through the queue
    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_MEASURE,
        KIND_APPLY
    } kind_t;

    // one queued word: kind, pixel and its precomputed mean
    typedef struct packed {
        kind_t             kind;
        logic [CHAN_W-1:0] mean;
        logic [CHAN_W-1:0] pix_b;
        logic [CHAN_W-1:0] pix_g;
        logic [CHAN_W-1:0] pix_r;
    } item_t;

    // control from the back sequencer to each divider lane
    typedef struct packed {
        logic start;
        logic step;
    } lane_ctrl_t;

    // back sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- design/wpcb_front.sv -----
`default_nettype none

module wpcb_front (
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_b,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_g,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_r,
    input  wire logic                        q_full,
    output logic                             push,
    output wpcb_pkg::item_t                  push_item
);
    import wpcb_pkg::*;

    // floor(sum/3) as (sum*683) >> 11, exact for sums up to 765
    localparam int SUM_W      = CHAN_W + 2;
    localparam int MEAN_SHIFT = 11;
    localparam int PROD_W     = SUM_W + MEAN_SHIFT;
    localparam logic [MEAN_SHIFT-1:0] MEAN_MUL = MEAN_SHIFT'(683);

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic              known_op;

    // accept whenever the queue has room
    assign s_ready = !q_full;

    // form the pixel mean
    assign sum  = {2'b00, s_pix_b} + {2'b00, s_pix_g} + {2'b00, s_pix_r};
    assign prod = PROD_W'(sum) * PROD_W'(MEAN_MUL);

    // classify the word; drop the unused op code
    always_comb begin
        push_item.kind  = KIND_CLEAR;
        known_op        = 1'b1;
        unique case (s_op)
            OP_CLEAR:   push_item.kind = KIND_CLEAR;
            OP_MEASURE: push_item.kind = KIND_MEASURE;
            OP_APPLY:   push_item.kind = KIND_APPLY;
            default:    known_op = 1'b0;
        endcase
        push_item.mean  = prod[MEAN_SHIFT +: CHAN_W];
        push_item.pix_b = s_pix_b;
        push_item.pix_g = s_pix_g;
        push_item.pix_r = s_pix_r;
    end

    assign push = s_valid && s_ready && known_op;

endmodule

`default_nettype wire

// ----- design/wpcb_queue.sv -----
`default_nettype none

module wpcb_queue #(
    parameter int DEPTH = wpcb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wpcb_pkg::item_t      push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output wpcb_pkg::item_t      head_item
);
    import wpcb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/wpcb_div_lane.sv -----
`default_nettype none

module wpcb_div_lane (
    input  wire logic                        aclk,
    input  wpcb_pkg::lane_ctrl_t             ctrl,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] pix,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] div,
    output logic      [wpcb_pkg::CHAN_W-1:0] quot
);
    import wpcb_pkg::*;

    localparam int DVD_W = 2 * CHAN_W;

    logic [DVD_W-1:0]  dividend;
    logic [CHAN_W:0]   trial;
    logic [CHAN_W:0]   diff;
    logic              fits;
    logic [CHAN_W-1:0] rem_reg, rem_next;
    logic [CHAN_W-1:0] lo_reg, lo_next;
    logic [CHAN_W-1:0] quot_reg, quot_next;
    logic [CHAN_W-1:0] div_reg, div_next;
    logic              fixed_reg, fixed_next;

    // pix*255 as (pix << 8) - pix
    assign dividend = {pix, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, pix};

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, lo_reg[CHAN_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        quot_next  = quot_reg;
        div_next   = div_reg;
        fixed_next = fixed_reg;
        priority if (ctrl.start) begin
            div_next  = div;
            rem_next  = dividend[DVD_W-1:CHAN_W];
            lo_next   = dividend[CHAN_W-1:0];
            quot_next = '0;
            // zero divisor gives zero, pix >= div saturates
            if (div == '0) begin
                fixed_next = 1'b1;
            end else if (pix >= div) begin
                fixed_next = 1'b1;
                quot_next  = CHAN_MAX;
            end else begin
                fixed_next = 1'b0;
            end
        end else if (ctrl.step && !fixed_reg) begin
            rem_next  = fits ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
            lo_next   = {lo_reg[CHAN_W-2:0], 1'b0};
            quot_next = {quot_reg[CHAN_W-2:0], fits};
        end else begin
            fixed_next = fixed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        lo_reg    <= lo_next;
        quot_reg  <= quot_next;
        div_reg   <= div_next;
        fixed_reg <= fixed_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- design/wpcb_back.sv -----
`default_nettype none

module wpcb_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_not_empty,
    input  wpcb_pkg::item_t                  q_item,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_b,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_g,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_r
);
    import wpcb_pkg::*;

    localparam int STEP_W = (CHAN_W > 1) ? $clog2(CHAN_W) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHAN_W - 1);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CHAN_W-1:0] max_mean_reg, max_mean_next;
    logic [CHAN_W-1:0] bright_b_reg, bright_b_next;
    logic [CHAN_W-1:0] bright_g_reg, bright_g_next;
    logic [CHAN_W-1:0] bright_r_reg, bright_r_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAN_W-1:0] m_out_b_reg, m_out_b_next;
    logic [CHAN_W-1:0] m_out_g_reg, m_out_g_next;
    logic [CHAN_W-1:0] m_out_r_reg, m_out_r_next;
    lane_ctrl_t        lane_ctrl;
    logic [CHAN_W-1:0] quot_b, quot_g, quot_r;

    // one divider lane per channel
    wpcb_div_lane u_lane_b (
        .aclk (aclk),
        .ctrl (lane_ctrl),
        .pix  (q_item.pix_b),
        .div  (bright_b_reg),
        .quot (quot_b)
    );

    wpcb_div_lane u_lane_g (
        .aclk (aclk),
        .ctrl (lane_ctrl),
        .pix  (q_item.pix_g),
        .div  (bright_g_reg),
        .quot (quot_g)
    );

    wpcb_div_lane u_lane_r (
        .aclk (aclk),
        .ctrl (lane_ctrl),
        .pix  (q_item.pix_r),
        .div  (bright_r_reg),
        .quot (quot_r)
    );

    // sequence words: update statistics, or run the dividers and emit
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        max_mean_next  = max_mean_reg;
        bright_b_next  = bright_b_reg;
        bright_g_next  = bright_g_reg;
        bright_r_next  = bright_r_reg;
        m_out_b_next   = m_out_b_reg;
        m_out_g_next   = m_out_g_reg;
        m_out_r_next   = m_out_r_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        pop            = 1'b0;
        lane_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    pop = 1'b1;
                    unique case (q_item.kind)
                        KIND_CLEAR: begin
                            max_mean_next = '0;
                            bright_b_next = '0;
                            bright_g_next = '0;
                            bright_r_next = '0;
                        end
                        KIND_MEASURE: begin
                            if (q_item.mean > max_mean_reg) begin
                                max_mean_next = q_item.mean;
                                bright_b_next = q_item.pix_b;
                                bright_g_next = q_item.pix_g;
                                bright_r_next = q_item.pix_r;
                            end
                        end
                        KIND_APPLY: begin
                            lane_ctrl.start = 1'b1;
                            step_next       = '0;
                            state_next      = ST_DIV;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                lane_ctrl.step = 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_out_b_next = quot_b;
                    m_out_g_next = quot_g;
                    m_out_r_next = quot_r;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            max_mean_reg <= '0;
            bright_b_reg <= '0;
            bright_g_reg <= '0;
            bright_r_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            max_mean_reg <= max_mean_next;
            bright_b_reg <= bright_b_next;
            bright_g_reg <= bright_g_next;
            bright_r_reg <= bright_r_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // hold the result word
    always_ff @(posedge aclk) begin
        m_out_b_reg <= m_out_b_next;
        m_out_g_reg <= m_out_g_next;
        m_out_r_reg <= m_out_r_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_b = m_out_b_reg;
    assign m_out_g = m_out_g_reg;
    assign m_out_r = m_out_r_reg;

`ifndef SYNTH
    // a clear word zeroes all statistics
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_item.kind == KIND_CLEAR) |=>
            (max_mean_reg == '0 && bright_b_reg == '0 &&
             bright_g_reg == '0 && bright_r_reg == '0))
        else $error("statistics not cleared");

    // the stored maximum only grows between clears
    a_max_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_item.kind == KIND_CLEAR) |=> (max_mean_reg >= $past(max_mean_reg)))
        else $error("stored maximum decreased");

    // a new result appears only on leaving the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // the kept pixel's channels stay put while the dividers run
    a_stats_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> $stable(bright_b_reg) && $stable(bright_g_reg) &&
            $stable(bright_r_reg))
        else $error("divisor changed during divide");
`endif

endmodule

`default_nettype wire

// ----- design/white_patch_color_balance_top.sv -----
`default_nettype none

// White-patch color balance over 8-bit BGR pixels. Each input word carries an op:
// clear starts a new frame's statistics, measure keeps the pixel with the largest
// integer mean (ties keep the earlier pixel), and apply returns one result word with
// each channel scaled to min(255, floor(p*255/c)), c being the kept pixel's channel
// (0 when c is 0). Op code 3 is accepted and dropped. Words pass from the input
// handshake into a small queue (QUEUE_DEPTH words), then to a sequencer. Clear and
// measure words retire at one per cycle while the sequencer is idle. An apply word
// passes through the sequencer as a load, 8 steps of the three per-channel bit-serial
// restoring dividers, and a load of the output register. The output register lets new
// words enter the queue while a result waits for m_ready.
module white_patch_color_balance_top #(
    parameter int QUEUE_DEPTH = wpcb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_b,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_g,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_r,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_b,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_g,
    output logic      [wpcb_pkg::CHAN_W-1:0] m_out_r
);
    import wpcb_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_not_empty;
    item_t head_item;

    // accept and classify
    wpcb_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_pix_b   (s_pix_b),
        .s_pix_g   (s_pix_g),
        .s_pix_r   (s_pix_r),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decouple front and back
    wpcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // execute words and drive results
    wpcb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_b     (m_out_b),
        .m_out_g     (m_out_g),
        .m_out_r     (m_out_r)
    );

endmodule

`default_nettype wire

// ----- verif/wpcb_result_checker.sv -----
`default_nettype none

module wpcb_result_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_b,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_g,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] s_pix_r,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] m_out_b,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] m_out_g,
    input  wire logic [wpcb_pkg::CHAN_W-1:0] m_out_r,
    output int                               error_count,
    output int                               results_owed
);
    import wpcb_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
    } bgr_t;

    localparam int PIX_CHANNELS = 3;
    localparam int SHOWN_MAX    = 10;

    // brightest pixel of the current frame, judged by its integer mean
    logic [CHAN_W-1:0] peak_mean;
    bgr_t              peak_pix;
    bgr_t              corrected_due[$];

    // scale one channel so the kept value maps to full scale, saturate
    function automatic logic [CHAN_W-1:0] stretch_channel(
        input logic [CHAN_W-1:0] p,
        input logic [CHAN_W-1:0] c
    );
        logic [2*CHAN_W-1:0] q;
        if (c == '0)
            return '0;
        q = ({{CHAN_W{1'b0}}, p} * {{CHAN_W{1'b0}}, CHAN_MAX}) / {{CHAN_W{1'b0}}, c};
        if (q > {{CHAN_W{1'b0}}, CHAN_MAX})
            return CHAN_MAX;
        return q[CHAN_W-1:0];
    endfunction

    always @(posedge aclk) begin
        bgr_t                got;
        bgr_t                want;
        logic [CHAN_W+1:0]   sum;
        logic [CHAN_W-1:0]   mean;
        if (!aresetn) begin
            peak_mean = '0;
            peak_pix  = '0;
            corrected_due.delete();
        end else begin
            // retire a result word against the oldest correction owed
            if (m_valid && m_ready) begin
                got = '{b: m_out_b, g: m_out_g, r: m_out_r};
                if (corrected_due.size() == 0) begin
                    if (error_count < SHOWN_MAX)
                        $display("%0t: result word with none owed: b=%0d g=%0d r=%0d",
                                 $time, got.b, got.g, got.r);
                    error_count++;
                end else begin
                    want = corrected_due.pop_front();
                    if (got.b !== want.b || got.g !== want.g || got.r !== want.r) begin
                        if (error_count < SHOWN_MAX)
                            $display({"%0t: mismatch: expected b=%0d g=%0d r=%0d, ",
                                      "got b=%0d g=%0d r=%0d"},
                                     $time, want.b, want.g, want.r, got.b, got.g, got.r);
                        error_count++;
                    end
                end
            end
            // advance the frame statistics for an accepted pixel word
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_CLEAR: begin
                        peak_mean = '0;
                        peak_pix  = '0;
                    end
                    OP_MEASURE: begin
                        sum  = {2'b00, s_pix_b} + {2'b00, s_pix_g} + {2'b00, s_pix_r};
                        mean = CHAN_W'(sum / PIX_CHANNELS);
                        // ties keep the earlier pixel
                        if (mean > peak_mean) begin
                            peak_mean = mean;
                            peak_pix  = '{b: s_pix_b, g: s_pix_g, r: s_pix_r};
                        end
                    end
                    OP_APPLY: begin
                        corrected_due.push_back('{b: stretch_channel(s_pix_b, peak_pix.b),
                                                  g: stretch_channel(s_pix_g, peak_pix.g),
                                                  r: stretch_channel(s_pix_r, peak_pix.r)});
                    end
                    default: begin
                        // unused op: drop
                    end
                endcase
            end
        end
        results_owed <= corrected_due.size();
    end

endmodule

`default_nettype wire

// ----- verif/tb_white_patch_color_balance_top.sv -----
`default_nettype none

module tb_white_patch_color_balance_top;
    import wpcb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int TOTAL_WORDS      = 1400;
    localparam int RANDOM_PHASES    = 8;
    localparam int HOLD_PHASE       = 4;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int CYCLE_LIMIT      = 400000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SENDER,
        STALL_RECEIVER,
        STALL_BOTH
    } stall_mode_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_op    = OP_CLEAR;
    logic [CHAN_W-1:0] s_pix_b = '0;
    logic [CHAN_W-1:0] s_pix_g = '0;
    logic [CHAN_W-1:0] s_pix_r = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAN_W-1:0] m_out_b;
    logic [CHAN_W-1:0] m_out_g;
    logic [CHAN_W-1:0] m_out_r;
    int                error_count;
    int                results_owed;

    stall_mode_t stall_mode    = STALL_NONE;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          words_sent    = 0;
    int          cycle_count   = 0;

    white_patch_color_balance_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_pix_b (s_pix_b),
        .s_pix_g (s_pix_g),
        .s_pix_r (s_pix_r),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out_b (m_out_b),
        .m_out_g (m_out_g),
        .m_out_r (m_out_r)
    );

    wpcb_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_pix_b      (s_pix_b),
        .s_pix_g      (s_pix_g),
        .s_pix_r      (s_pix_r),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_b      (m_out_b),
        .m_out_g      (m_out_g),
        .m_out_r      (m_out_r),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // end a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise random stalls per mode
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (stall_mode)
                STALL_RECEIVER: m_ready <= ($urandom_range(99) >= 83);
                STALL_BOTH:     m_ready <= ($urandom_range(99) >= 7);
                default:        m_ready <= 1'b1;
            endcase
        end
    end

    function automatic bit sender_waits();
        case (stall_mode)
            STALL_SENDER: return $urandom_range(99) < 83;
            STALL_BOTH:   return $urandom_range(99) < 7;
            default:      return 1'b0;
        endcase
    endfunction

    // bias toward the channel extremes now and then
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CHAN_MAX;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    // offer one pixel word and hold it until accepted
    task automatic send_word(
        input logic [1:0]        op,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] r
    );
        while (sender_waits()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_pix_b <= b;
        s_pix_g <= g;
        s_pix_r <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    task automatic send_random(input logic [1:0] op);
        send_word(op, rand_chan(), rand_chan(), rand_chan());
    endtask

    // pause the input until every owed result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (results_owed != 0);
        @(posedge aclk);
    endtask

    // one frame: usually a clear, measure pass, apply pass, then maybe a stray word
    task automatic send_frame();
        int n_measure;
        int n_apply;
        n_measure = $urandom_range(8, 1);
        n_apply   = $urandom_range(8, 1);
        if ($urandom_range(9) != 0)
            send_random(OP_CLEAR);
        repeat (n_measure)
            send_random(OP_MEASURE);
        repeat (n_apply)
            send_random(OP_APPLY);
        if ($urandom_range(4) == 0)
            send_random(2'($urandom_range(3)));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // statistics still zero after reset: every channel outputs zero
        send_word(OP_APPLY,   8'd0,   8'd128, 8'd255);
        // all-black pixel ties the zero maximum and is not kept
        send_word(OP_MEASURE, 8'd0,   8'd0,   8'd0);
        send_word(OP_APPLY,   8'd255, 8'd255, 8'd255);
        send_word(OP_MEASURE, 8'd1,   8'd1,   8'd2);
        // saturation on blue, zero on green, partial on red
        send_word(OP_APPLY,   8'd255, 8'd0,   8'd1);
        // equal mean keeps the earlier pixel
        send_word(OP_MEASURE, 8'd3,   8'd0,   8'd0);
        send_word(OP_APPLY,   8'd1,   8'd1,   8'd2);
        send_word(OP_UNUSED,  8'd255, 8'd255, 8'd255);
        send_word(OP_MEASURE, 8'd255, 8'd255, 8'd255);
        send_word(OP_MEASURE, 8'd255, 8'd255, 8'd254);
        send_word(OP_APPLY,   8'd255, 8'd255, 8'd255);
        send_word(OP_APPLY,   8'd0,   8'd0,   8'd0);
        send_word(OP_APPLY,   8'd128, 8'd1,   8'd254);
        send_word(OP_CLEAR,   8'd255, 8'd255, 8'd255);
        send_word(OP_APPLY,   8'd200, 8'd200, 8'd200);
        // kept pixel with a zero green channel
        send_word(OP_MEASURE, 8'd200, 8'd0,   8'd100);
        send_word(OP_APPLY,   8'd10,  8'd255, 8'd50);
        send_word(OP_MEASURE, 8'd0,   8'd255, 8'd0);
        send_word(OP_MEASURE, 8'd101, 8'd101, 8'd101);
        send_word(OP_APPLY,   8'd202, 8'd50,  8'd255);
        send_word(OP_CLEAR,   8'd0,   8'd0,   8'd0);
        // mean rounds down to zero and is not kept
        send_word(OP_MEASURE, 8'd1,   8'd0,   8'd0);
        send_word(OP_APPLY,   8'd1,   8'd1,   8'd1);
        drain_results();

        // random frames, cycling through the stall modes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            stall_mode = stall_mode_t'(phase % 4);
            // back up the result side while input keeps coming
            if (phase == HOLD_PHASE)
                hold_requests++;
            while (words_sent < TOTAL_WORDS * (phase + 1) / RANDOM_PHASES)
                send_frame();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
